### sv/adc_average_rate_clock_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion macros for the block average and time-of-day clock.
// ---------------------------------------------------------------------------
`ifndef ADC_AVERAGE_RATE_CLOCK_DEFINES_SVH
`define ADC_AVERAGE_RATE_CLOCK_DEFINES_SVH

`ifndef ASSERT_OFF
`define AARC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define AARC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define AARC_ASSERT(lbl, clk, rst_n, prop)
`define AARC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### sv/aarc_pkg.sv
// ---------------------------------------------------------------------------
// Block average clock package
// Types and constants shared by the window averager, the time-of-day clock
// and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aarc_pkg;

	localparam int WINDOW_LEN_DEF = 20;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [11:0] AVG_RESET = 12'd2000;

	localparam logic [7:0] SUB_LIMIT  = 8'd100;
	localparam logic [5:0] SEC_LAST   = 6'd59;
	localparam logic [5:0] MIN_LAST   = 6'd59;
	localparam logic [4:0] HOUR_LAST  = 5'd23;
	localparam logic [5:0] SEC_RESET  = 6'd45;
	localparam logic [5:0] MIN_RESET  = 6'd59;
	localparam logic [4:0] HOUR_RESET = 5'd23;

	// Division of a 12-bit value by 100 as a multiply and shift.
	localparam int          DIV100_SHIFT = 19;
	localparam logic [12:0] DIV100_MUL   = 13'((2**19 + 99) / 100);

	// Scaling to millivolts, floor(a * 3000 / 4095) = floor(a * 200 / 273).
	localparam int          MV_SHIFT = 29;
	localparam logic [28:0] MV_MUL   = 29'(200 * ((2**29 + 272) / 273));

	typedef struct packed {
		logic [11:0] average;
		logic        done;
		logic        mv_on;
	} aarc_win_t;

	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
	} aarc_time_t;

endpackage

### sv/adc_average_rate_clock.sv
// ---------------------------------------------------------------------------
// Block average and time-of-day clock
// Averages converter samples over a window, scales the average to
// millivolts and runs a time-of-day clock paced by the average.
// ---------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  in       in_valid / in_ready   command, sample
//  out      out_valid / out_ready hours, minutes, seconds, average,
//                                 millivolts, window_done
//
//  One request per cycle while out_ready does not stall the pipeline.
//  Stage 1 is the input register, stage 2 updates the window and clock
//  state, stage 3 scales the average to millivolts into the output register.
//  Each stage holds while the next one is full and stalled, so a stall on
//  out_ready fills the pipeline before in_ready falls.
//  Reset is asynchronous and clears all control state at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_average_rate_clock #(
	parameter int WINDOW_LEN = aarc_pkg::WINDOW_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  hours,
	output logic [5:0]  minutes,
	output logic [5:0]  seconds,
	output logic [11:0] average,
	output logic [11:0] millivolts,
	output logic        window_done
);
	import aarc_pkg::*;

	logic        v1_q;
	logic        v2_q;
	logic        v3_q;
	logic        cmd_s1;
	logic [11:0] sample_s1;
	aarc_win_t   win_s2;
	aarc_time_t  tm_s2;
	aarc_win_t   win_res;
	aarc_time_t  tm_res;
	logic [11:0] avg_cur;
	logic        r2;
	logic        r3;
	logic        adv1;
	logic        adv2;
	logic        in_acc;
	logic [40:0] mv_prod;

	assign r3       = !v3_q || out_ready;
	assign r2       = !v2_q || r3;
	assign in_ready = !v1_q || r2;
	assign in_acc   = in_valid && in_ready;
	assign adv1     = v1_q && r2;
	assign adv2     = v2_q && r3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= 1'b1;
			end else if (adv2) begin
				v2_q <= 1'b0;
			end
			if (adv2) begin
				v3_q <= 1'b1;
			end else if (out_ready) begin
				v3_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1    <= command;
			sample_s1 <= sample;
		end
	end

	aarc_window #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv1),
		.is_sample(cmd_s1 == CMD_SAMPLE),
		.sample   (sample_s1),
		.avg_cur  (avg_cur),
		.res      (win_res)
	);

	aarc_clock u_clock (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv1),
		.is_tick(cmd_s1 == CMD_TICK),
		.avg_cur(avg_cur),
		.res    (tm_res)
	);

	always_ff @(posedge clk) begin
		if (adv1) begin
			win_s2 <= win_res;
			tm_s2  <= tm_res;
		end
	end

	assign mv_prod = 41'(win_s2.average) * 41'(MV_MUL);

	always_ff @(posedge clk) begin
		if (adv2) begin
			hours       <= tm_s2.hours;
			minutes     <= tm_s2.minutes;
			seconds     <= tm_s2.seconds;
			average     <= win_s2.average;
			millivolts  <= win_s2.mv_on ? mv_prod[MV_SHIFT +: 12] : 12'd0;
			window_done <= win_s2.done;
		end
	end

	assign out_valid = v3_q;

endmodule

### sv/aarc_window.sv
// ---------------------------------------------------------------------------
// Window averager
// Sums samples over a window and holds the floor average of the last
// completed window.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adc_average_rate_clock_defines.svh"

module aarc_window #(
	parameter int WINDOW_LEN = aarc_pkg::WINDOW_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               is_sample,
	input  logic [11:0]        sample,
	output logic [11:0]        avg_cur,
	output aarc_pkg::aarc_win_t res
);
	import aarc_pkg::*;

	localparam int IDX_W   = $clog2(WINDOW_LEN);
	localparam int SUM_W   = $clog2(WINDOW_LEN * 4095 + 1);
	localparam int SHIFT   = SUM_W + $clog2(WINDOW_LEN);
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
	localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
	localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(WINDOW_LEN - 1);

	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [11:0]       avg_q;
	logic              mv_on_q;
	logic [SUM_W-1:0]  sum_nx;
	logic [PROD_W-1:0] prod;
	logic [11:0]       avg_nx;
	logic              last;
	logic              take;

	assign sum_nx = sum_q + SUM_W'(sample);
	assign last   = (idx_q == IDX_LAST);
	assign prod   = PROD_W'(sum_nx) * PROD_W'(RECIP);
	assign avg_nx = prod[SHIFT +: 12];
	assign take   = step && is_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			avg_q   <= AVG_RESET;
			mv_on_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				idx_q   <= '0;
				sum_q   <= '0;
				avg_q   <= avg_nx;
				mv_on_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
				sum_q <= sum_nx;
			end
		end
	end

	assign avg_cur = avg_q;

	always_comb begin
		res.done    = is_sample && last;
		res.average = res.done ? avg_nx : avg_q;
		res.mv_on   = mv_on_q || res.done;
	end

	`AARC_ASSERT(a_idx_range, clk, arst_n, int'(idx_q) < WINDOW_LEN)
	`AARC_ASSERT_NEXT(a_window_clear, clk, arst_n, take && last, idx_q == '0 && sum_q == '0)
	`AARC_ASSERT_NEXT(a_idx_count, clk, arst_n, take && !last, idx_q == IDX_W'($past(idx_q) + 1'b1))
	`AARC_ASSERT_NEXT(a_mv_sticky, clk, arst_n, mv_on_q, mv_on_q)

endmodule

### sv/aarc_clock.sv
// ---------------------------------------------------------------------------
// Time-of-day clock
// Advances a sub-second counter by one plus the average divided by 100 on
// each tick and carries into seconds, minutes and hours.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adc_average_rate_clock_defines.svh"

module aarc_clock (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 is_tick,
	input  logic [11:0]          avg_cur,
	output aarc_pkg::aarc_time_t res
);
	import aarc_pkg::*;

	logic [7:0]  sub_q;
	logic [5:0]  sec_q;
	logic [5:0]  min_q;
	logic [4:0]  hour_q;
	logic [24:0] div_prod;
	logic [7:0]  sub_sum;
	logic        wrap;
	logic [7:0]  sub_nx;
	aarc_time_t  tm_nx;
	logic        take;

	assign div_prod = 25'(avg_cur) * 25'(DIV100_MUL);
	assign sub_sum  = sub_q + 8'(div_prod[24:DIV100_SHIFT]) + 8'd1;
	assign wrap     = sub_sum > SUB_LIMIT;
	assign take     = step && is_tick;

	always_comb begin
		sub_nx  = sub_sum;
		tm_nx.seconds = sec_q;
		tm_nx.minutes = min_q;
		tm_nx.hours   = hour_q;
		if (wrap) begin
			sub_nx = '0;
			if (sec_q == SEC_LAST) begin
				tm_nx.seconds = '0;
				if (min_q == MIN_LAST) begin
					tm_nx.minutes = '0;
					tm_nx.hours   = (hour_q == HOUR_LAST) ? '0 : hour_q + 1'b1;
				end else begin
					tm_nx.minutes = min_q + 1'b1;
				end
			end else begin
				tm_nx.seconds = sec_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q  <= '0;
			sec_q  <= SEC_RESET;
			min_q  <= MIN_RESET;
			hour_q <= HOUR_RESET;
		end else if (take) begin
			sub_q  <= sub_nx;
			sec_q  <= tm_nx.seconds;
			min_q  <= tm_nx.minutes;
			hour_q <= tm_nx.hours;
		end
	end

	always_comb begin
		if (is_tick) begin
			res = tm_nx;
		end else begin
			res.seconds = sec_q;
			res.minutes = min_q;
			res.hours   = hour_q;
		end
	end

	`AARC_ASSERT(a_sub_range, clk, arst_n, sub_q <= SUB_LIMIT)
	`AARC_ASSERT(a_time_range, clk, arst_n, sec_q <= SEC_LAST && min_q <= MIN_LAST && hour_q <= HOUR_LAST)
	`AARC_ASSERT_NEXT(a_hold_idle, clk, arst_n, !take, $stable(sub_q) && $stable(sec_q) && $stable(min_q) && $stable(hour_q))

endmodule
